// ===== hdl/sparse_matrix_transpose_assert.svh =====
// ----------------------------------------------------------------------------
// Sparse matrix transpose assertion macros
// Shared assertion shorthands for the sparse matrix transpose store.
// ----------------------------------------------------------------------------
`ifndef SPARSE_MATRIX_TRANSPOSE_ASSERT_SVH
`define SPARSE_MATRIX_TRANSPOSE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/smt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sparse matrix transpose package
// Sizes, codes, types and value helpers shared by the transpose store.
// ----------------------------------------------------------------------------
package smt_pkg;

    // Matrix dimension and stored value width.
    localparam int MAX_DIM    = 64;
    localparam int VALUE_BITS = 32;

    // Derived widths.
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W  = $clog2(MAX_DIM + 1);
    localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int EXT_W  = (VALUE_BITS > 32) ? VALUE_BITS : 32;

    // Configuration reset value.
    localparam logic [6:0] NUM_COLS_RESET = 7'd64;

    // Command kinds.
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_STORED = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_READ   = 2'd3;

    typedef logic signed [VALUE_BITS-1:0] t_val;

    // One slot of a column list.
    typedef struct packed {
        logic [6:0] row;
        t_val       value;
    } t_slot;

    // Slot memory write request.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_slot             data;
    } t_slot_wr;

    // Sign-extend the 32-bit input value and wrap it to the stored width.
    function automatic t_val load_value(logic signed [31:0] v);
        logic signed [EXT_W-1:0] ext;
        begin
            ext = EXT_W'(v);
            return ext[VALUE_BITS-1:0];
        end
    endfunction

    // Low 32 bits of the sign-extended stored value.
    function automatic logic [31:0] out_value(t_val v);
        logic signed [EXT_W-1:0] ext;
        begin
            ext = EXT_W'(v);
            return ext[31:0];
        end
    endfunction

endpackage

// ===== hdl/smt_slot_ram.sv =====
// ----------------------------------------------------------------------------
// Sparse matrix transpose slot memory
// One write port and one registered read port holding all column lists.
// ----------------------------------------------------------------------------
module smt_slot_ram (
    input  logic              i_clk,
    input  smt_pkg::t_slot_wr i_wr,
    input  logic [smt_pkg::ADDR_W-1:0] i_rd_addr,
    output smt_pkg::t_slot    o_rd_data
);

    smt_pkg::t_slot mem_slot [2**smt_pkg::ADDR_W];
    smt_pkg::t_slot r_rd_data;

    // Write and registered read, one of each per cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem_slot[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= mem_slot[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/sparse_matrix_transpose.sv =====
// ----------------------------------------------------------------------------
// Sparse matrix transpose store
// Files entries under their column in row order, reads columns back and clears all columns.
// ----------------------------------------------------------------------------
//
// Channel    Direction  Handshake              Payload
// command    in         start && !busy         i_kind, i_row_index,
//                                              i_column_index, i_value
// result     out        o_strobe (one cycle)   o_status, o_out_row, o_out_col,
//                                              o_out_value, o_entry_count, o_last
// config     in         i_cfg_we               i_cfg_wdata
//
// Clear and out-of-range commands answer in the next cycle; busy stays low.
// An insert reads the column count, then shifts each larger slot up one place, then writes
// the new entry and bumps the count; on a full column it answers ST_FULL with no write.
// A read of N entries gives one result per cycle, o_last on the Nth (one on an empty column).
// Reset is synchronous; column counts are cleared at once through per-column valid bits.
// The receiver cannot stall: every result is taken in the cycle it is shown.
// ----------------------------------------------------------------------------
`include "sparse_matrix_transpose_assert.svh"

module sparse_matrix_transpose (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [6:0]  i_row_index,
    input  logic [6:0]  i_column_index,
    input  logic signed [31:0] i_value,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [6:0]  o_out_row,
    output logic [6:0]  o_out_col,
    output logic [31:0] o_out_value,
    output logic [6:0]  o_entry_count,
    output logic        o_last
);

    localparam int IDX_W = smt_pkg::IDX_W;
    localparam int CNT_W = smt_pkg::CNT_W;
    localparam int CMP_W = smt_pkg::CMP_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FILL  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_PLACE = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]           r_state, n_state;
    logic [6:0]           r_num_cols;
    logic [1:0]           r_kind, n_kind;
    logic [6:0]           r_row, n_row;
    logic [6:0]           r_col_in, n_col_in;
    smt_pkg::t_val        r_val, n_val;
    logic [CNT_W-1:0]     r_fill, n_fill;
    logic [IDX_W-1:0]     r_pos, n_pos;
    logic [smt_pkg::MAX_DIM-1:0] r_col_valid, n_col_valid;

    logic                 r_strobe, n_strobe;
    logic [1:0]           r_status, n_status;
    logic [6:0]           r_out_row, n_out_row;
    logic [6:0]           r_out_col, n_out_col;
    logic [31:0]          r_out_value, n_out_value;
    logic [6:0]           r_count, n_count;
    logic                 r_last, n_last;

    logic [CNT_W-1:0]     mem_fill [smt_pkg::MAX_DIM];
    logic [CNT_W-1:0]     r_fill_q;
    logic [IDX_W-1:0]     fill_raddr;
    logic                 fill_we;

    logic                 accept;
    logic [6:0]           in_col_m1;
    logic [IDX_W-1:0]     in_idx;
    logic [IDX_W-1:0]     col_idx;
    logic [CMP_W-1:0]     col_limit;
    logic                 col_ok;
    logic [CNT_W-1:0]     eff_fill;
    logic                 after;
    logic                 emit_last;

    smt_pkg::t_slot_wr    slot_wr;
    logic [smt_pkg::ADDR_W-1:0] slot_raddr;
    smt_pkg::t_slot       slot_q;

    smt_slot_ram u_slot_ram (
        .i_clk     (i_clk),
        .i_wr      (slot_wr),
        .i_rd_addr (slot_raddr),
        .o_rd_data (slot_q)
    );

    // Command decode and column range check.
    assign accept    = start && !busy;
    assign in_col_m1 = i_column_index - 7'd1;
    assign in_idx    = in_col_m1[IDX_W-1:0];
    assign col_limit = (CMP_W'(r_num_cols) > CMP_W'(smt_pkg::MAX_DIM)) ?
                       CMP_W'(smt_pkg::MAX_DIM) : CMP_W'(r_num_cols);
    assign col_ok    = (i_column_index != 7'd0) && (CMP_W'(i_column_index) <= col_limit);

    // Working column, its effective fill and the insert order compare.
    assign col_idx   = IDX_W'(r_col_in - 7'd1);
    assign eff_fill  = r_col_valid[col_idx] ? r_fill_q : '0;
    assign after     = (slot_q.row > r_row) ||
                       ((slot_q.row == r_row) && ($signed(slot_q.value) > $signed(r_val)));
    assign emit_last = ((CNT_W'(r_pos) + CNT_W'(1)) == r_fill);

    // Sequencer next-state and datapath control.
    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_row       = r_row;
        n_col_in    = r_col_in;
        n_val       = r_val;
        n_fill      = r_fill;
        n_pos       = r_pos;
        n_col_valid = r_col_valid;
        n_strobe    = 1'b0;
        n_status    = r_status;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_value = r_out_value;
        n_count     = r_count;
        n_last      = r_last;
        fill_raddr  = in_idx;
        fill_we     = 1'b0;
        slot_raddr  = '0;
        slot_wr     = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind   = i_kind;
                    n_row    = i_row_index;
                    n_col_in = i_column_index;
                    n_val    = smt_pkg::load_value(i_value);
                    case (i_kind)
                        smt_pkg::KIND_CLEAR: begin
                            n_col_valid = '0;
                            n_strobe    = 1'b1;
                            n_status    = smt_pkg::ST_STORED;
                            n_out_row   = '0;
                            n_out_col   = '0;
                            n_out_value = '0;
                            n_count     = '0;
                            n_last      = 1'b1;
                        end
                        smt_pkg::KIND_INSERT, smt_pkg::KIND_READ: begin
                            if (!col_ok) begin
                                n_strobe    = 1'b1;
                                n_status    = smt_pkg::ST_RANGE;
                                n_out_row   = '0;
                                n_out_col   = '0;
                                n_out_value = '0;
                                n_count     = '0;
                                n_last      = 1'b1;
                            end else begin
                                n_state = S_FILL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_FILL: begin
                n_fill = eff_fill;
                if (r_kind == smt_pkg::KIND_INSERT) begin
                    if (eff_fill >= CNT_W'(smt_pkg::MAX_DIM)) begin
                        n_strobe    = 1'b1;
                        n_status    = smt_pkg::ST_FULL;
                        n_out_row   = '0;
                        n_out_col   = '0;
                        n_out_value = '0;
                        n_count     = 7'(eff_fill);
                        n_last      = 1'b1;
                        n_state     = S_IDLE;
                    end else if (eff_fill == '0) begin
                        n_pos   = '0;
                        n_state = S_PLACE;
                    end else begin
                        slot_raddr = {col_idx, IDX_W'(eff_fill - CNT_W'(1))};
                        n_pos      = IDX_W'(eff_fill);
                        n_state    = S_SCAN;
                    end
                end else begin
                    if (eff_fill == '0) begin
                        n_strobe    = 1'b1;
                        n_status    = smt_pkg::ST_READ;
                        n_out_row   = r_col_in;
                        n_out_col   = '0;
                        n_out_value = '0;
                        n_count     = '0;
                        n_last      = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        slot_raddr = {col_idx, {IDX_W{1'b0}}};
                        n_pos      = '0;
                        n_state    = S_EMIT;
                    end
                end
            end

            // Shift one larger slot up per cycle while reading the next one down.
            S_SCAN: begin
                if (after) begin
                    slot_wr.en   = 1'b1;
                    slot_wr.addr = {col_idx, r_pos};
                    slot_wr.data = slot_q;
                    n_pos        = r_pos - IDX_W'(1);
                    if (r_pos > IDX_W'(1)) begin
                        slot_raddr = {col_idx, IDX_W'(r_pos - IDX_W'(2))};
                    end else begin
                        n_state = S_PLACE;
                    end
                end else begin
                    n_state = S_PLACE;
                end
            end

            // Write the new entry into its slot and bump the column count.
            S_PLACE: begin
                slot_wr.en         = 1'b1;
                slot_wr.addr       = {col_idx, r_pos};
                slot_wr.data.row   = r_row;
                slot_wr.data.value = r_val;
                fill_raddr         = col_idx;
                fill_we            = 1'b1;
                n_col_valid[col_idx] = 1'b1;
                n_strobe    = 1'b1;
                n_status    = smt_pkg::ST_STORED;
                n_out_row   = '0;
                n_out_col   = '0;
                n_out_value = '0;
                n_count     = 7'(r_fill + CNT_W'(1));
                n_last      = 1'b1;
                n_state     = S_IDLE;
            end

            // Emit one entry per cycle in list order.
            S_EMIT: begin
                n_strobe    = 1'b1;
                n_status    = smt_pkg::ST_READ;
                n_out_row   = r_col_in;
                n_out_col   = slot_q.row;
                n_out_value = smt_pkg::out_value(slot_q.value);
                n_count     = 7'(r_fill);
                n_last      = emit_last;
                if (emit_last) begin
                    n_state = S_IDLE;
                end else begin
                    slot_raddr = {col_idx, IDX_W'(r_pos + IDX_W'(1))};
                    n_pos      = r_pos + IDX_W'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Column count memory with registered read.
    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            mem_fill[col_idx] <= r_fill + CNT_W'(1);
        end
        r_fill_q <= mem_fill[fill_raddr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_strobe    <= 1'b0;
            r_col_valid <= '0;
            r_num_cols  <= smt_pkg::NUM_COLS_RESET;
        end else begin
            r_state     <= n_state;
            r_strobe    <= n_strobe;
            r_col_valid <= n_col_valid;
            if (i_cfg_we) begin
                r_num_cols <= i_cfg_wdata;
            end
        end
    end

    // Transaction and result payload registers.
    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_row       <= n_row;
        r_col_in    <= n_col_in;
        r_val       <= n_val;
        r_fill      <= n_fill;
        r_pos       <= n_pos;
        r_status    <= n_status;
        r_out_row   <= n_out_row;
        r_out_col   <= n_out_col;
        r_out_value <= n_out_value;
        r_count     <= n_count;
        r_last      <= n_last;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_out_row     = r_out_row;
    assign o_out_col     = r_out_col;
    assign o_out_value   = r_out_value;
    assign o_entry_count = r_count;
    assign o_last        = r_last;

    // Assertions on the sequencer and the result stream.
    `SMT_ASSERT_SAME(a_scan_pos, i_clk, i_rst_n, r_state == S_SCAN, r_pos != '0,
                     "scan with slot zero")
    `SMT_ASSERT_SAME(a_emit_fill, i_clk, i_rst_n, r_state == S_EMIT, r_fill != '0,
                     "read burst on empty column")
    `SMT_ASSERT_NEXT(a_burst, i_clk, i_rst_n, o_strobe && !o_last,
                     o_strobe && (o_status == smt_pkg::ST_READ), "read burst broken")
    `SMT_ASSERT_NEXT(a_clear, i_clk, i_rst_n, accept && (i_kind == smt_pkg::KIND_CLEAR),
                     (r_col_valid == '0) && o_strobe, "clear not applied")
    `SMT_ASSERT_SAME(a_busy_quiet, i_clk, i_rst_n, o_strobe && !o_last, busy,
                     "burst while idle")

endmodule
